FILE: hw/rtl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types and constants for the header/tail frame deframer.
// ----------------------------------------------------------------------------
package htfd_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] CFG_HEADER = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_TAIL = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 2'd2;

	localparam logic [7:0] HeaderReset = 8'hee;
	localparam logic [31:0] TailReset = 32'hfffc_ffff;
	localparam logic [7:0] MaxPayloadReset = 8'd95;
	localparam logic [7:0] LimitCap = 8'd251;
	localparam int unsigned WinDepth = 4;

	typedef enum logic [1:0] {
		ST_PAYLOAD = 2'd0,
		ST_EMPTY = 2'd1,
		ST_DROP = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] header_value;
		logic [31:0] tail_pattern;
		logic [7:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic [7:0] payload_byte;
		logic last;
		status_t status;
	} result_t;

endpackage

FILE: hw/rtl/header_tail_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// header_tail_frame_deframer_core
// Removes header and tail bytes from a received byte stream.
// ----------------------------------------------------------------------------
// Received bytes enter on the rx channel (in_valid, in_ready, rx_byte), one
// transaction per byte. Bytes are discarded until the header byte is seen.
// Inside a frame, each payload byte leaves four bytes after it arrived, on
// the out channel (out_valid, out_ready, payload_byte, last, status).
// The final payload byte carries last; an empty frame gives an empty-frame
// status, and a frame over the length limit gives a drop status.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// Throughput is one byte per cycle while in_ready is high. Each result is
// registered in the output register; if the receiver stalls, one more
// result is held in a skid register and in_ready falls only when both the
// output and skid registers are full. Reset clears the frame state, both
// registers and restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module header_tail_frame_deframer_core
	import htfd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] payload_byte,
	output logic last,
	output logic [1:0] status,
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [CfgDataW-1:0] cfg_data
);

	cfg_t cfg_q;
	result_t res;
	result_t out_q;
	result_t skid_q;
	logic fire;
	logic out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_value <= HeaderReset;
			cfg_q.tail_pattern <= TailReset;
			cfg_q.max_payload <= MaxPayloadReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER: cfg_q.header_value <= cfg_data[7:0];
				CFG_TAIL: cfg_q.tail_pattern <= cfg_data[31:0];
				CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !skid_q.valid;
	assign fire = in_valid && in_ready;
	assign out_fire = out_q.valid && out_ready;

	htfd_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.rx_byte(rx_byte),
		.cfg(cfg_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
			skid_q <= '0;
		end else if (skid_q.valid) begin
			if (out_fire) begin
				out_q <= skid_q;
				skid_q.valid <= 1'b0;
			end
		end else if (res.valid) begin
			if (!out_q.valid || out_fire) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (out_fire) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid = out_q.valid;
	assign payload_byte = out_q.payload_byte;
	assign last = out_q.last;
	assign status = out_q.status;

endmodule

FILE: hw/rtl/htfd_frame.sv
// ----------------------------------------------------------------------------
// htfd_frame
// Frame state, tail window and result decision for one accepted byte.
// ----------------------------------------------------------------------------
module htfd_frame
	import htfd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [7:0] rx_byte,
	input cfg_t cfg,
	output result_t res
);

	logic in_frame_q;
	logic [7:0] cnt_q;
	logic [7:0] win_q [WinDepth];

	logic [7:0] limit;
	logic [8:0] count;
	logic has_payload;
	logic tail_hit;
	logic drop;
	logic [31:0] new_win;

	always_comb begin
		limit = (cfg.max_payload > LimitCap) ? LimitCap : cfg.max_payload;
		count = {1'b0, cnt_q} + 9'd1;
		has_payload = (cnt_q >= 8'd4);
		new_win = {win_q[1], win_q[2], win_q[3], rx_byte};
		tail_hit = (count >= 9'd4) && (new_win == cfg.tail_pattern);
		drop = has_payload && ({1'b0, cnt_q} > ({1'b0, limit} + 9'd3));

		res.valid = 1'b0;
		res.payload_byte = 8'd0;
		res.last = 1'b0;
		res.status = ST_PAYLOAD;
		if (fire && in_frame_q) begin
			if (drop) begin
				res.valid = 1'b1;
				res.status = ST_DROP;
			end else if (tail_hit) begin
				res.valid = 1'b1;
				if (has_payload) begin
					res.payload_byte = win_q[0];
					res.last = 1'b1;
				end else begin
					res.status = ST_EMPTY;
				end
			end else if (has_payload) begin
				res.valid = 1'b1;
				res.payload_byte = win_q[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q <= 8'd0;
			for (int i = 0; i < WinDepth; i++) begin
				win_q[i] <= 8'd0;
			end
		end else if (fire) begin
			if (!in_frame_q) begin
				if (rx_byte == cfg.header_value) begin
					in_frame_q <= 1'b1;
					cnt_q <= 8'd0;
					for (int i = 0; i < WinDepth; i++) begin
						win_q[i] <= 8'd0;
					end
				end
			end else if (drop || tail_hit) begin
				in_frame_q <= 1'b0;
				cnt_q <= 8'd0;
				for (int i = 0; i < WinDepth; i++) begin
					win_q[i] <= 8'd0;
				end
			end else begin
				cnt_q <= count[7:0];
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= win_q[3];
				win_q[3] <= rx_byte;
			end
		end
	end

endmodule

FILE: hw/rtl/htfd_checker.sv
// ----------------------------------------------------------------------------
// htfd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module htfd_checker
	import htfd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] payload_byte,
	input logic last,
	input logic [1:0] status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
			&& $stable(last) && $stable(status))
		else $error("Stalled output transaction changed.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_PAYLOAD) || (status == ST_EMPTY)
			|| (status == ST_DROP))
		else $error("Unknown status code.");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_PAYLOAD) |-> (payload_byte == 8'd0) && !last)
		else $error("Non-payload result carries payload fields.");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("Input stalled with an empty output register.");

endmodule

bind header_tail_frame_deframer_core htfd_checker u_htfd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.payload_byte(payload_byte),
	.last(last),
	.status(status)
);
